@@ rtl/rpm_pkg.sv @@
`default_nettype none

package rpm_pkg;

  localparam int HUE_BITS    = 12;
  localparam int SAT_BITS    = 8;
  localparam int LIMIT_BITS  = 12;
  localparam int HUE_CMP_W   = (HUE_BITS > LIMIT_BITS) ? HUE_BITS : LIMIT_BITS;
  localparam int STEPS_PER_STAGE = 2;
  localparam int HUE_STAGES  = (HUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SAT_STAGES  = (SAT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DIV_STAGES  = (HUE_STAGES > SAT_STAGES) ? HUE_STAGES : SAT_STAGES;
  localparam int LATENCY     = DIV_STAGES + 2;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic                  is_red;
    logic [LIMIT_BITS-1:0] hue;
    logic [7:0]            saturation;
    logic [7:0]            brightness;
  } result_t;

  typedef enum logic [1:0] {
    REG_HUE_LOW  = 2'd0,
    REG_HUE_HIGH = 2'd1,
    REG_SAT_THR  = 2'd2,
    REG_VAL_THR  = 2'd3
  } reg_idx_e;

  // divider pipeline payload; remainders stay below their divisors except for gray and full-saturation items
  typedef struct packed {
    logic                gray;
    logic                sat_full;
    logic [7:0]          brightness;
    logic [10:0]         hue_rem;
    logic [10:0]         hue_div;
    logic [HUE_BITS-1:0] hue_q;
    logic [7:0]          sat_rem;
    logic [7:0]          sat_div;
    logic [SAT_BITS-1:0] sat_q;
  } div_t;

endpackage

`default_nettype wire

@@ rtl/red_pixel_mask.sv @@
// Channel   Direction  Handshake              Payload
// pixel     in         start high, busy low   pixel_i  (blue, green, red)
// result    out        result_valid_o strobe  result_o (is_red, hue, saturation, brightness)
// config    in         APB psel/penable       paddr, pwdata, prdata
//
// One item enters per cycle; each result passes the entry register, the
// restoring divider stages for hue and saturation (two quotient bits per
// stage) and the threshold register. busy stays low: the result side
// cannot stall, so the pipeline always advances. Reset clears valid bits and
// loads the default thresholds.
`default_nettype none

module red_pixel_mask (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire rpm_pkg::pixel_t pixel_i,
  output logic                 result_valid_o,
  output rpm_pkg::result_t     result_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rpm_pkg::*;

  logic [LIMIT_BITS-1:0] hue_low_q, hue_high_q;
  logic [7:0]            sat_thr_q, val_thr_q;
  reg_idx_e              reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= LIMIT_BITS'(410);
      hue_high_q <= LIMIT_BITS'(3891);
      sat_thr_q  <= 8'd102;
      val_thr_q  <= 8'd38;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_HUE_LOW:  hue_low_q  <= pwdata[LIMIT_BITS-1:0];
        REG_HUE_HIGH: hue_high_q <= pwdata[LIMIT_BITS-1:0];
        REG_SAT_THR:  sat_thr_q  <= pwdata[7:0];
        REG_VAL_THR:  val_thr_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HUE_LOW:  prdata = 32'(hue_low_q);
      REG_HUE_HIGH: prdata = 32'(hue_high_q);
      REG_SAT_THR:  prdata = 32'(sat_thr_q);
      REG_VAL_THR:  prdata = 32'(val_thr_q);
      default:      prdata = '0;
    endcase
  end

  // entry stage: max, min, delta, hue numerator
  logic [7:0]  mx, mn, delta;
  logic [10:0] d6;
  logic [11:0] num;
  div_t        entry_d;

  always_comb begin
    mx = pixel_i.red;
    mn = pixel_i.red;
    if (pixel_i.green > mx) mx = pixel_i.green;
    if (pixel_i.blue > mx)  mx = pixel_i.blue;
    if (pixel_i.green < mn) mn = pixel_i.green;
    if (pixel_i.blue < mn)  mn = pixel_i.blue;
    delta = mx - mn;
    d6 = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    if (pixel_i.red == mx) begin
      num = {4'b0, pixel_i.green} - {4'b0, pixel_i.blue};
      if (num[11]) num = num + {1'b0, d6};
    end else if (pixel_i.green == mx) begin
      num = {3'b0, delta, 1'b0} + {4'b0, pixel_i.blue} - {4'b0, pixel_i.red};
    end else begin
      num = {2'b0, delta, 2'b0} + {4'b0, pixel_i.red} - {4'b0, pixel_i.green};
    end
    entry_d.gray       = (delta == 8'd0);
    entry_d.sat_full   = (mn == 8'd0) && (mx != 8'd0);
    entry_d.brightness = mx;
    entry_d.hue_rem    = num[10:0];
    entry_d.hue_div    = d6;
    entry_d.hue_q      = '0;
    entry_d.sat_rem    = delta;
    entry_d.sat_div    = mx;
    entry_d.sat_q      = '0;
  end

  logic [DIV_STAGES:0] vld_q;
  div_t                stg_q [DIV_STAGES+1];
  div_t                stg_d [DIV_STAGES+1];

  // divider stages: restoring steps, one quotient bit per step
  always_comb begin
    div_t        cur;
    logic [11:0] hsh;
    logic [8:0]  ssh;
    stg_d[0] = entry_d;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = stg_q[k];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (k * STEPS_PER_STAGE + j < HUE_BITS) begin
          hsh = {cur.hue_rem, 1'b0};
          if (hsh >= {1'b0, cur.hue_div}) begin
            hsh = hsh - {1'b0, cur.hue_div};
            cur.hue_q = {cur.hue_q[HUE_BITS-2:0], 1'b1};
          end else begin
            cur.hue_q = {cur.hue_q[HUE_BITS-2:0], 1'b0};
          end
          cur.hue_rem = hsh[10:0];
        end
        if (k * STEPS_PER_STAGE + j < SAT_BITS) begin
          ssh = {cur.sat_rem, 1'b0};
          if (ssh >= {1'b0, cur.sat_div}) begin
            ssh = ssh - {1'b0, cur.sat_div};
            cur.sat_q = {cur.sat_q[SAT_BITS-2:0], 1'b1};
          end else begin
            cur.sat_q = {cur.sat_q[SAT_BITS-2:0], 1'b0};
          end
          cur.sat_rem = ssh[7:0];
        end
      end
      stg_d[k+1] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-1:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      stg_q[k] <= stg_d[k];
    end
  end

  // threshold stage
  div_t                 fin;
  logic [HUE_CMP_W-1:0] hue_ext;
  logic [7:0]           sat;
  result_t              result_d, result_q;
  logic                 result_valid_q;

  always_comb begin
    fin     = stg_q[DIV_STAGES];
    hue_ext = fin.gray ? '0 : HUE_CMP_W'(fin.hue_q);
    if (fin.gray)          sat = 8'd0;
    else if (fin.sat_full) sat = 8'd255;
    else                   sat = fin.sat_q;
    result_d.hue        = hue_ext[LIMIT_BITS-1:0];
    result_d.saturation = sat;
    result_d.brightness = fin.brightness;
    result_d.is_red     = ((hue_ext < HUE_CMP_W'(hue_low_q)) ||
                           (hue_ext > HUE_CMP_W'(hue_high_q))) &&
                          (sat > sat_thr_q) && (fin.brightness > val_thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("item did not come out after the pipeline latency");

  a_black_not_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.brightness == 8'd0) |-> !result_o.is_red)
    else $error("black pixel marked red");

  a_gray_not_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.saturation == 8'd0) |-> !result_o.is_red)
    else $error("unsaturated pixel marked red");

  a_hue_needs_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.hue != '0) |-> (result_o.saturation != 8'd0))
    else $error("nonzero hue with zero saturation");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rpm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pixel_t      pixel_i;
  logic        result_valid_o;
  result_t     result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the thresholds
  logic [11:0] hue_lo_lim;
  logic [11:0] hue_hi_lim;
  logic [7:0]  sat_thr;
  logic [7:0]  val_thr;

  result_t     pending_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          burst = 1'b0;

  red_pixel_mask dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pixel_i       (pixel_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic result_t hsv_of(pixel_t p);
    int      b, g, r, mx, mn, d, n;
    longint  h, s;
    result_t res;
    b = p.blue;
    g = p.green;
    r = p.red;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    h = 0;
    s = 0;
    if (d > 0) begin
      if (r == mx) n = g - b;
      else if (g == mx) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      if (n < 0) n += 6 * d;
      h = (longint'(n) << HUE_BITS) / (6 * d);
      h = h & ((longint'(1) << HUE_BITS) - 1);
      s = (longint'(d) * 256) / mx;
      if (s > 255) s = 255;
    end
    res.hue        = h[11:0];
    res.saturation = s[7:0];
    res.brightness = mx[7:0];
    res.is_red     = ((h < hue_lo_lim || h > hue_hi_lim) && s > sat_thr && mx > val_thr);
    return res;
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %p", result_o);
      end else begin
        want = pending_q.pop_front();
        if (result_o.is_red !== want.is_red || result_o.hue !== want.hue ||
            result_o.saturation !== want.saturation ||
            result_o.brightness !== want.brightness) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %p got %p", want, result_o);
        end
      end
    end
  end

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start   <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (busy);
    pending_q = {pending_q, hsv_of(p)};
  endtask

  task automatic send_bgr(int b, int g, int r);
    pixel_t p;
    p.blue  = b[7:0];
    p.green = g[7:0];
    p.red   = r[7:0];
    send_pixel(p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // write, then read back; upper data bits are random to check masking
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    logic [31:0] kept;
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_HUE_LOW:  hue_lo_lim = val[11:0];
      REG_HUE_HIGH: hue_hi_lim = val[11:0];
      REG_SAT_THR:  sat_thr    = val[7:0];
      REG_VAL_THR:  val_thr    = val[7:0];
      default: ;
    endcase
    kept = (idx == REG_HUE_LOW || idx == REG_HUE_HIGH) ? {20'd0, val[11:0]} : {24'd0, val[7:0]};
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom();
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      mismatches++;
      if (mismatches <= 10)
        $display("readback reg %s: want %h got %h", idx.name(), kept, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(int lo, int hi, int st, int vt);
    write_reg(REG_HUE_LOW,  {20'($urandom_range(0, 1048575)), lo[11:0]});
    write_reg(REG_HUE_HIGH, {20'($urandom_range(0, 1048575)), hi[11:0]});
    write_reg(REG_SAT_THR,  {24'($urandom_range(0, 16777215)), st[7:0]});
    write_reg(REG_VAL_THR,  {24'($urandom_range(0, 16777215)), vt[7:0]});
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     r;
    p = 24'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5: begin
        r = $urandom_range(30, 255);
        p.red   = r[7:0];
        p.green = 8'($urandom_range(0, r / 2));
        p.blue  = 8'($urandom_range(0, r / 2));
      end
      6: begin
        p.green = p.red;
        if ($urandom_range(0, 1)) p.blue = p.red;
      end
      7: begin
        p.blue = p.green;
      end
      8: begin
        p.red   = 8'($urandom_range(0, 3));
        p.green = 8'($urandom_range(0, 3));
        p.blue  = 8'($urandom_range(0, 3));
      end
      default: begin
        p.red  = p.blue;
      end
    endcase
    return p;
  endfunction

  task automatic test_special_pixels();
    send_bgr(0, 0, 0);
    send_bgr(255, 255, 255);
    send_bgr(128, 128, 128);
    send_bgr(0, 0, 255);
    send_bgr(0, 255, 0);
    send_bgr(255, 0, 0);
    send_bgr(10, 200, 200);
    send_bgr(200, 200, 10);
    send_bgr(200, 10, 200);
    send_bgr(200, 10, 255);
    send_bgr(0, 0, 1);
    send_bgr(254, 255, 255);
    send_bgr(0, 255, 255);
    send_bgr(255, 255, 0);
    send_bgr(255, 0, 255);
    send_bgr(40, 30, 250);
    send_bgr(30, 40, 250);
    send_bgr(0, 0, 39);
    send_bgr(0, 0, 38);
    send_bgr(170, 85, 255);
  endtask

  task automatic test_threshold_extremes();
    set_config(0, 4095, 0, 0);
    test_special_pixels();
    set_config(4095, 0, 255, 255);
    test_special_pixels();
    set_config(4095, 0, 0, 0);
    test_special_pixels();
  endtask

  task automatic test_random_pixels();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7)
        set_config(410, 3891, 102, 38);
      else
        set_config($urandom_range(0, 900), $urandom_range(3200, 4095),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      for (int i = 0; i < 250; i++) begin
        if (i % 25 == 0) burst = ($urandom_range(0, 3) == 0);
        send_pixel(random_pixel());
      end
      burst = 1'b0;
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    pixel_i = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    hue_lo_lim = 12'd410;
    hue_hi_lim = 12'd3891;
    sat_thr    = 8'd102;
    val_thr    = 8'd38;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_special_pixels();
    test_threshold_extremes();
    test_random_pixels();
    drain();

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
